[sv/hpc_pkg.sv]
package hpc_pkg;

	localparam int HEIGHT_BITS_DEF = 12;
	localparam int LOWEST_W        = 16;
	localparam int STATE_W_MIN     = 17;
	localparam int CFG_DATA_W      = 10;
	localparam int CFG_INDEX_W     = 2;
	localparam int BELT_BAND_W     = 10;
	localparam int FLAT_OFFSET_W   = 8;
	localparam int FLAT_BAND_W     = 10;

	localparam int BELT_BAND_RST   = 200;
	localparam int FLAT_OFFSET_RST = 25;
	localparam int FLAT_BAND_RST   = 200;
	localparam int BELT_LOW_RST    = 3600;
	localparam int BELT_HIGH_RST   = 0;
	localparam int FLAT_LOW_RST    = 60000;
	localparam int FLAT_HIGH_RST   = 2560;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BELT_BAND   = 2'd0,
		REG_FLAT_OFFSET = 2'd1,
		REG_FLAT_BAND   = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		EV_MARKER   = 2'd0,
		EV_FLAT     = 2'd1,
		EV_NOT_FLAT = 2'd2
	} event_t;

	typedef struct packed {
		logic [BELT_BAND_W-1:0]   belt_band;
		logic [FLAT_OFFSET_W-1:0] flat_offset;
		logic [FLAT_BAND_W-1:0]   flat_band;
	} cfg_t;

	typedef struct packed {
		logic   emit;
		event_t ev;
	} result_t;

endpackage

[sv/height_profile_classifier_core.sv]
// channel   signals                                    direction
// input     in_valid, in_ready, calibrating, height    in, one transfer per sample
// output    out_valid, out_ready, event_res            out, zero or one per sample
// config    wr_en, wr_index, wr_data                   in, write only, no wait
//
// one sample per cycle sustained unless a held result stalls; a transfer is captured in the
// sample register, which feeds one level of compare/add logic that updates the state
// and loads the result register in the same cycle
// a held result stalls only a sample that produces a result; others keep flowing
// asynchronous reset restores register and state defaults, no clearing pass
module height_profile_classifier_core
	import hpc_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   calibrating,
	input  logic [HEIGHT_BITS-1:0] height,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             event_res,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	logic                   valid_s1;
	logic                   calibrating_s1;
	logic [HEIGHT_BITS-1:0] height_s1;
	logic                   out_valid_q;
	event_t                 event_q;
	logic                   adv;
	cfg_t                   cfg;
	result_t                res;

	hpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hpc_eval #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.calibrating (calibrating_s1),
		.height      (height_s1),
		.cfg         (cfg),
		.res         (res)
	);

	assign adv      = valid_s1 && (!res.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			calibrating_s1 <= calibrating;
			height_s1      <= height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			event_q <= res.ev;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = event_q;

	a_sample_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(height_s1) && $stable(calibrating_s1))
		else $error("stalled sample lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.emit |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (event_q == EV_MARKER) || (event_q == EV_FLAT)
		|| (event_q == EV_NOT_FLAT))
		else $error("undefined result code");

endmodule

[sv/hpc_cfg_regs.sv]
module hpc_cfg_regs
	import hpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.belt_band   <= BELT_BAND_W'(BELT_BAND_RST);
			cfg_q.flat_offset <= FLAT_OFFSET_W'(FLAT_OFFSET_RST);
			cfg_q.flat_band   <= FLAT_BAND_W'(FLAT_BAND_RST);
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_BELT_BAND:   cfg_q.belt_band   <= wr_data[BELT_BAND_W-1:0];
				REG_FLAT_OFFSET: cfg_q.flat_offset <= wr_data[FLAT_OFFSET_W-1:0];
				REG_FLAT_BAND:   cfg_q.flat_band   <= wr_data[FLAT_BAND_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/hpc_eval.sv]
module hpc_eval
	import hpc_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   calibrating,
	input  logic [HEIGHT_BITS-1:0] height,
	input  cfg_t                   cfg,
	output result_t                res
);

	localparam int SW = (HEIGHT_BITS + 2 > STATE_W_MIN) ? HEIGHT_BITS + 2 : STATE_W_MIN;

	logic signed [SW-1:0] belt_low_q, belt_high_q, flat_low_q, flat_high_q;
	logic                 measuring_q, left_belt_q;
	logic [LOWEST_W-1:0]  lowest_q;

	logic signed [SW-1:0] belt_low_d, belt_high_d, flat_low_d, flat_high_d;
	logic                 measuring_d, left_belt_d;
	logic [LOWEST_W-1:0]  lowest_d;

	logic signed [SW-1:0] h, band, offset, fband, lo;
	logic [LOWEST_W-1:0]  h_lo;
	logic                 depart, lb_mid, back, on_belt, below;
	result_t              res_c;

	always_comb begin
		h      = signed'(SW'(height));
		h_lo   = LOWEST_W'(height);
		band   = signed'(SW'(cfg.belt_band));
		offset = signed'(SW'(cfg.flat_offset));
		fband  = signed'(SW'(cfg.flat_band));
		lo     = signed'(SW'(lowest_q));

		on_belt = (belt_high_q > h) && (h > belt_low_q);
		below   = h < belt_low_q;

		belt_low_d  = belt_low_q;
		belt_high_d = belt_high_q;
		flat_low_d  = flat_low_q;
		flat_high_d = flat_high_q;
		measuring_d = measuring_q;
		left_belt_d = left_belt_q;
		lowest_d    = lowest_q;
		res_c.emit  = 1'b0;
		res_c.ev    = EV_MARKER;

		depart = 1'b0;
		lb_mid = 1'b0;
		back   = 1'b0;

		if (calibrating) begin
			depart      = !left_belt_q && ((belt_high_q - h) > band);
			lb_mid      = left_belt_q || depart;
			back        = lb_mid && on_belt;
			left_belt_d = lb_mid && !back;
			res_c.emit  = depart || back;
			if (!left_belt_d && (belt_high_q < h)) begin
				belt_high_d = h;
				belt_low_d  = h - band;
			end
			if (flat_low_q > h) begin
				flat_low_d  = h - offset;
				flat_high_d = h - offset + fband;
			end
		end else if (!measuring_q) begin
			if (!on_belt && below) begin
				measuring_d = 1'b1;
				if (h_lo < lowest_q) begin
					lowest_d = h_lo;
				end
				res_c.emit = 1'b1;
			end
		end else begin
			if (below && (h_lo < lowest_q)) begin
				lowest_d = h_lo;
			end
			if (on_belt) begin
				res_c.emit  = 1'b1;
				res_c.ev    = ((flat_high_q > lo) && (lo > flat_low_q)) ? EV_FLAT : EV_NOT_FLAT;
				measuring_d = 1'b0;
				lowest_d    = '1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			belt_low_q  <= SW'(BELT_LOW_RST);
			belt_high_q <= SW'(BELT_HIGH_RST);
			flat_low_q  <= SW'(FLAT_LOW_RST);
			flat_high_q <= SW'(FLAT_HIGH_RST);
			measuring_q <= 1'b0;
			left_belt_q <= 1'b0;
			lowest_q    <= '1;
		end else if (step) begin
			belt_low_q  <= belt_low_d;
			belt_high_q <= belt_high_d;
			flat_low_q  <= flat_low_d;
			flat_high_q <= flat_high_d;
			measuring_q <= measuring_d;
			left_belt_q <= left_belt_d;
			lowest_q    <= lowest_d;
		end
	end

	assign res = res_c;

	a_lowest_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!measuring_q |-> lowest_q == {LOWEST_W{1'b1}})
		else $error("lowest reading not cleared outside a measurement");

	a_verdict_needs_meas: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_c.emit && (res_c.ev != EV_MARKER) |-> measuring_q && !calibrating)
		else $error("verdict without open measurement");

	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_c.emit && (res_c.ev != EV_MARKER) |=> !measuring_q)
		else $error("measurement still open after verdict");

	a_open_marks: assert property (@(posedge clk) disable iff (!arst_n)
		step && !calibrating && !measuring_q && measuring_d |-> res_c.emit
		&& (res_c.ev == EV_MARKER))
		else $error("measurement opened without marker");

endmodule
